// ----- src/pixel_window_reducer_assert.svh -----
// ----------------------------------------------------------------------------
// Pixel window reducer assertion macros
// Shorthand for the concurrent checks kept in the window engine.
// ----------------------------------------------------------------------------
`ifndef PIXEL_WINDOW_REDUCER_ASSERT_SVH
`define PIXEL_WINDOW_REDUCER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PWR_CHECK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define PWR_CHECK_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/pwr_pkg.sv -----
// ----------------------------------------------------------------------------
// Pixel window reducer package
// Shared constants, codes, types and a helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package pwr_pkg;

   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned PIXEL_W  = 12;
   localparam int unsigned BEST_W   = 13;
   localparam int unsigned TOTAL_W  = 20;
   localparam int unsigned OUT_W    = 16;
   localparam int unsigned REG_IDX_W = 3;
   localparam int unsigned CSR_W    = 8;
   localparam int unsigned SUM_SHIFT = 4;

   localparam logic [COUNT_W-1:0] MAX_SPAN    = 8'd255;
   localparam logic [BEST_W-1:0]  DARK_SEED   = 13'd5000;
   localparam logic [PIXEL_W-1:0] FIXED_PIXEL = 12'd555;

   localparam logic [7:0] HI_MASK     = 8'h1F;
   localparam logic [7:0] LO_MASK_10  = 8'hF8;
   localparam logic [7:0] LO_MASK_12  = 8'hFE;

   // Operating modes
   localparam logic [1:0] MODE_PASS = 2'd0;
   localparam logic [1:0] MODE_SUM  = 2'd1;
   localparam logic [1:0] MODE_BEST = 2'd2;
   localparam logic [1:0] MODE_RSVD = 2'd3;

   // Converter formats
   localparam logic [1:0] FMT_DIRECT = 2'd0;
   localparam logic [1:0] FMT_SPI10  = 2'd1;
   localparam logic [1:0] FMT_SPI12  = 2'd2;
   localparam logic [1:0] FMT_FIXED  = 2'd3;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_FORMAT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_INNER  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_OUTER  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_AMP    = 3'd4;

   typedef struct packed {
      logic [1:0]         mode;
      logic [1:0]         adc_format;
      logic [COUNT_W-1:0] inner_count;
      logic [COUNT_W-1:0] outer_count;
      logic               amp_in_use;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [OUT_W-1:0]   pixel_value;
      logic [COUNT_W-1:0] best_line;
      logic [COUNT_W-1:0] best_position;
      logic               last;
   } res_type;

   // Zero counts act as one, oversized counts clip to the span limit.
   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] r;
      if (count == '0) begin
         r = {{(COUNT_W-1){1'b0}}, 1'b1};
      end else if (count > MAX_SPAN) begin
         r = MAX_SPAN;
      end else begin
         r = count;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/pwr_csr.sv -----
// ----------------------------------------------------------------------------
// Pixel window reducer control registers
// Holds the configuration written over the csr channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pwr_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [pwr_pkg::REG_IDX_W-1:0] csr_index,
   input  wire logic [pwr_pkg::CSR_W-1:0]     csr_data,
   output pwr_pkg::cfg_type                   cfg
);
   import pwr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MODE:   cfg_in.mode        = csr_data[1:0];
            REG_FORMAT: cfg_in.adc_format  = csr_data[1:0];
            REG_INNER:  cfg_in.inner_count = csr_data[COUNT_W-1:0];
            REG_OUTER:  cfg_in.outer_count = csr_data[COUNT_W-1:0];
            REG_AMP:    cfg_in.amp_in_use  = csr_data[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= MODE_PASS;
         cfg_ff.adc_format  <= FMT_DIRECT;
         cfg_ff.inner_count <= 8'd8;
         cfg_ff.outer_count <= 8'd8;
         cfg_ff.amp_in_use  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/pwr_decode.sv -----
// ----------------------------------------------------------------------------
// Pixel window reducer sample decoder
// Turns a converter reading into a pixel value per the selected format.
// ----------------------------------------------------------------------------
`default_nettype none

module pwr_decode (
   input  wire logic [1:0]                  adc_format,
   input  wire logic [7:0]                  high_byte,
   input  wire logic [7:0]                  low_byte,
   input  wire logic [9:0]                  direct_sample,
   output logic [pwr_pkg::PIXEL_W-1:0]      pixel
);
   import pwr_pkg::*;

   logic [7:0] hi_m;
   logic [7:0] lo10_m;
   logic [7:0] lo12_m;

   always_comb begin
      hi_m   = high_byte & HI_MASK;
      lo10_m = low_byte & LO_MASK_10;
      lo12_m = low_byte & LO_MASK_12;
      case (adc_format)
         FMT_DIRECT: pixel = {2'b00, direct_sample};
         FMT_SPI10:  pixel = {2'b00, hi_m[4:0], lo10_m[7:3]};
         FMT_SPI12:  pixel = {hi_m[4:0], lo12_m[7:1]};
         FMT_FIXED:  pixel = FIXED_PIXEL;
         default:    pixel = FIXED_PIXEL;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/pwr_engine.sv -----
// ----------------------------------------------------------------------------
// Pixel window reducer window engine
// Scan counters, line sum and brightest- or darkest-pixel search; forms one result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_window_reducer_assert.svh"

module pwr_engine (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire pwr_pkg::cfg_type            cfg,
   input  wire logic [pwr_pkg::PIXEL_W-1:0] pixel,
   output pwr_pkg::res_type                 res
);
   import pwr_pkg::*;

   logic [COUNT_W-1:0] pos_ff,   pos_in;
   logic [COUNT_W-1:0] line_ff,  line_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [BEST_W-1:0]  best_ff,  best_in;
   logic [COUNT_W-1:0] bline_ff, bline_in;
   logic [COUNT_W-1:0] bpos_ff,  bpos_in;

   logic [COUNT_W-1:0] inner;
   logic [COUNT_W-1:0] outer;
   logic               line_end;
   logic               window_end;
   logic               window_start;
   logic [TOTAL_W-1:0] total_sum;
   logic [TOTAL_W-1:0] shifted;
   logic [OUT_W-1:0]   sum_out;
   logic [BEST_W-1:0]  best_base;
   logic [COUNT_W-1:0] bline_base;
   logic [COUNT_W-1:0] bpos_base;
   logic [BEST_W-1:0]  pixel_ext;
   logic               wins;

   always_comb begin
      inner        = eff_count(cfg.inner_count);
      outer        = eff_count(cfg.outer_count);
      line_end     = ({1'b0, pos_ff} + 9'd1) >= {1'b0, inner};
      window_end   = line_end && (({1'b0, line_ff} + 9'd1) >= {1'b0, outer});
      window_start = (pos_ff == '0) && (line_ff == '0);

      // Restart the line sum on the first pixel of each line
      total_sum = ((pos_ff == '0) ? '0 : total_ff)
                  + {{(TOTAL_W-PIXEL_W){1'b0}}, pixel};
      shifted   = total_sum >> SUM_SHIFT;
      sum_out   = (|shifted[TOTAL_W-1:OUT_W]) ? {OUT_W{1'b1}} : shifted[OUT_W-1:0];

      // Reseed the search at window start
      best_base  = window_start ? (cfg.amp_in_use ? '0 : DARK_SEED) : best_ff;
      bline_base = window_start ? '0 : bline_ff;
      bpos_base  = window_start ? '0 : bpos_ff;
      pixel_ext  = {{(BEST_W-PIXEL_W){1'b0}}, pixel};
      wins       = cfg.amp_in_use ? (pixel_ext > best_base) : (pixel_ext < best_base);

      pos_in   = pos_ff;
      line_in  = line_ff;
      total_in = total_ff;
      best_in  = best_ff;
      bline_in = bline_ff;
      bpos_in  = bpos_ff;
      if (step) begin
         total_in = total_sum;
         best_in  = wins ? pixel_ext : best_base;
         bline_in = wins ? line_ff : bline_base;
         bpos_in  = wins ? pos_ff : bpos_base;
         if (line_end) begin
            pos_in  = '0;
            line_in = window_end ? '0 : line_ff + 8'd1;
         end else begin
            pos_in  = pos_ff + 8'd1;
         end
      end

      res = '0;
      case (cfg.mode)
         MODE_PASS: begin
            res.valid       = 1'b1;
            res.pixel_value = {{(OUT_W-PIXEL_W){1'b0}}, pixel};
            res.last        = window_end;
         end
         MODE_SUM: begin
            res.valid       = line_end;
            res.pixel_value = sum_out;
            res.last        = window_end;
         end
         MODE_BEST: begin
            res.valid         = window_end;
            res.best_line     = wins ? line_ff : bline_base;
            res.best_position = wins ? pos_ff : bpos_base;
            res.last          = 1'b1;
         end
         default: res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         line_ff  <= '0;
         total_ff <= '0;
         best_ff  <= DARK_SEED;
         bline_ff <= '0;
         bpos_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         total_ff <= total_in;
         best_ff  <= best_in;
         bline_ff <= bline_in;
         bpos_ff  <= bpos_in;
      end
   end

   `PWR_CHECK(a_pos_in_span, clock, reset, pos_ff < MAX_SPAN, "position counter past span limit")
   `PWR_CHECK(a_best_is_last, clock, reset, !(res.valid && cfg.mode == MODE_BEST) || res.last, "search result without window end")
   `PWR_CHECK_NEXT(a_window_wrap, clock, reset, step && window_end, pos_ff == '0 && line_ff == '0, "counters did not wrap at window end")
   `PWR_CHECK_NEXT(a_pos_advance, clock, reset, step && !line_end, pos_ff == $past(pos_ff) + 8'd1, "position did not advance")

endmodule

`default_nettype wire

// ----- src/pixel_window_reducer.sv -----
// ----------------------------------------------------------------------------
// Pixel window reducer
// Decodes one converter reading per pixel of a scanned window and emits
// pixels, line sums or the brightest- or darkest-pixel location.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   req_tdata: high, low, direct
//   rsp      out        rsp_tvalid/rsp_tready   rsp_tdata, rsp_tlast
//   csr      in         csr_valid/csr_ready     csr_index, csr_data
//
// One request per clock sustained while rsp is not stalled; a request passes
// the input register, then the result register.
// Decode, line accumulate and best compare all sit between those registers.
// A stalled rsp holds its result; one more request waits in the input
// register, and req_tready falls only when both are full.
// Reset is synchronous and returns registers to defaults and the scan to
// the first pixel of a window. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_window_reducer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // req_tdata: [7:0] high_byte, [15:8] low_byte, [25:16] direct_sample, rest zero
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [31:0]                   req_tdata,
   // rsp_tdata: [15:0] pixel_value, [23:16] best_line, [31:24] best_position
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [31:0]                        rsp_tdata,
   output logic                               rsp_tlast,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [pwr_pkg::REG_IDX_W-1:0] csr_index,
   input  wire logic [pwr_pkg::CSR_W-1:0]     csr_data
);
   import pwr_pkg::*;

   cfg_type cfg;
   res_type res;

   // Input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_high_ff,  s1_high_in;
   logic [7:0]  s1_low_ff,   s1_low_in;
   logic [9:0]  s1_direct_ff, s1_direct_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff,  rsp_data_in;
   logic        rsp_last_ff,  rsp_last_in;

   logic               out_free;
   logic               advance;
   logic               step;
   logic [PIXEL_W-1:0] pixel;

   pwr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pwr_decode u_decode (
      .adc_format    (cfg.adc_format),
      .high_byte     (s1_high_ff),
      .low_byte      (s1_low_ff),
      .direct_sample (s1_direct_ff),
      .pixel         (pixel)
   );

   pwr_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cfg   (cfg),
      .pixel (pixel),
      .res   (res)
   );

   always_comb begin
      // Result slot can take a new value when empty or draining this cycle
      out_free   = !rsp_valid_ff || rsp_tready;
      // Process the held request whenever the result slot is free
      step       = s1_valid_ff && out_free;
      advance    = !s1_valid_ff || out_free;
      req_tready = advance;

      s1_valid_in  = s1_valid_ff;
      s1_high_in   = s1_high_ff;
      s1_low_in    = s1_low_ff;
      s1_direct_in = s1_direct_ff;
      if (advance) begin
         s1_valid_in  = req_tvalid;
         s1_high_in   = req_tdata[7:0];
         s1_low_in    = req_tdata[15:8];
         s1_direct_in = req_tdata[25:16];
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = step && res.valid;
         rsp_data_in  = {res.best_position, res.best_line, res.pixel_value};
         rsp_last_in  = res.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holds need no reset
   always_ff @(posedge clock) begin
      s1_high_ff   <= s1_high_in;
      s1_low_ff    <= s1_low_in;
      s1_direct_ff <= s1_direct_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- dv/pixel_window_reducer_checker.sv -----
// ----------------------------------------------------------------------------
// Pixel window reducer checker
// Watches the request, result and register channels, predicts every result
// from its own copy of the scan state and compares it with what comes out.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_window_reducer_checker
   import pwr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [31:0]          req_tdata,
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [31:0]          rsp_tdata,
   input  wire logic                 rsp_tlast,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [REG_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data,
   output int unsigned               error_count,
   output int unsigned               owed_count
);

   typedef struct packed {
      logic [OUT_W-1:0]   pixel_value;
      logic [COUNT_W-1:0] best_line;
      logic [COUNT_W-1:0] best_position;
      logic               last;
   } reduction_t;

   cfg_type            shadow_cfg;
   logic [COUNT_W-1:0] col_idx;
   logic [COUNT_W-1:0] row_idx;
   logic [TOTAL_W-1:0] row_sum;
   logic [BEST_W-1:0]  peak_value;
   logic [COUNT_W-1:0] peak_row;
   logic [COUNT_W-1:0] peak_col;
   reduction_t         owed_reductions[$];
   int unsigned        errors = 0;

   function automatic int unsigned span_of(input logic [COUNT_W-1:0] count);
      if (count == '0) return 1;
      if (count > MAX_SPAN) return 32'(MAX_SPAN);
      return 32'(count);
   endfunction

   function automatic int unsigned decode_sample(input logic [31:0] word);
      int unsigned hi;
      int unsigned lo;
      int unsigned pix;
      hi = 32'(word[7:0]);
      lo = 32'(word[15:8]);
      case (shadow_cfg.adc_format)
         FMT_DIRECT: pix = 32'(word[25:16]);
         FMT_SPI10:  pix = ((hi & HI_MASK) << 5) + ((lo & LO_MASK_10) >> 3);
         FMT_SPI12:  pix = ((hi & HI_MASK) << 7) + ((lo & LO_MASK_12) >> 1);
         default:    pix = 32'(FIXED_PIXEL);
      endcase
      return pix;
   endfunction

   task automatic predict_reduction(input logic [31:0] word);
      int unsigned pix;
      int unsigned cols;
      int unsigned rows;
      logic        row_done;
      logic        frame_done;
      reduction_t  r;
      pix        = decode_sample(word);
      cols       = span_of(shadow_cfg.inner_count);
      rows       = span_of(shadow_cfg.outer_count);
      row_done   = (32'(col_idx) + 1) >= cols;
      frame_done = row_done && ((32'(row_idx) + 1) >= rows);

      // reseed the search on the first pixel of every window
      if (col_idx == '0 && row_idx == '0) begin
         peak_value = shadow_cfg.amp_in_use ? '0 : DARK_SEED;
         peak_row   = '0;
         peak_col   = '0;
      end
      if (col_idx == '0) row_sum = '0;
      row_sum = row_sum + TOTAL_W'(pix);

      if (shadow_cfg.amp_in_use ? (pix > peak_value) : (pix < peak_value)) begin
         peak_value = BEST_W'(pix);
         peak_row   = row_idx;
         peak_col   = col_idx;
      end

      r = '0;
      case (shadow_cfg.mode)
         MODE_PASS: begin
            r.pixel_value = OUT_W'(pix);
            r.last        = frame_done;
            owed_reductions.push_back(r);
         end
         MODE_SUM: begin
            // a 20-bit total shifted by four always fits 16 bits
            if (row_done) begin
               r.pixel_value = OUT_W'(row_sum >> SUM_SHIFT);
               r.last        = frame_done;
               owed_reductions.push_back(r);
            end
         end
         MODE_BEST: begin
            if (frame_done) begin
               r.best_line     = peak_row;
               r.best_position = peak_col;
               r.last          = 1'b1;
               owed_reductions.push_back(r);
            end
         end
         default: ; // reserved mode: count the pixel, emit nothing
      endcase

      if (row_done) begin
         col_idx = '0;
         row_idx = frame_done ? '0 : row_idx + 1'b1;
      end else begin
         col_idx = col_idx + 1'b1;
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_reduction();
      reduction_t want;
      if (owed_reductions.size() == 0) begin
         errors++;
         $display("%0t: unexpected result: expected none, actual data 0x%08h last %0b",
                  $time, rsp_tdata, rsp_tlast);
      end else begin
         want = owed_reductions.pop_front();
         compare_field("pixel_value", 32'(want.pixel_value), 32'(rsp_tdata[15:0]));
         compare_field("best_line", 32'(want.best_line), 32'(rsp_tdata[23:16]));
         compare_field("best_position", 32'(want.best_position), 32'(rsp_tdata[31:24]));
         compare_field("last", 32'(want.last), 32'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg.mode        = MODE_PASS;
         shadow_cfg.adc_format  = FMT_DIRECT;
         shadow_cfg.inner_count = 8'd8;
         shadow_cfg.outer_count = 8'd8;
         shadow_cfg.amp_in_use  = 1'b0;
         col_idx    = '0;
         row_idx    = '0;
         row_sum    = '0;
         peak_value = DARK_SEED;
         peak_row   = '0;
         peak_col   = '0;
         owed_reductions.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE:   shadow_cfg.mode        = csr_data[1:0];
               REG_FORMAT: shadow_cfg.adc_format  = csr_data[1:0];
               REG_INNER:  shadow_cfg.inner_count = csr_data;
               REG_OUTER:  shadow_cfg.outer_count = csr_data;
               REG_AMP:    shadow_cfg.amp_in_use  = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_reduction(req_tdata);
         if (rsp_tvalid && rsp_tready) check_reduction();
      end
      error_count <= errors;
      owed_count  <= owed_reductions.size();
   end

endmodule

`default_nettype wire

// ----- dv/pixel_window_reducer_tb.sv -----
// ----------------------------------------------------------------------------
// Pixel window reducer testbench
// Drives pixel requests and register writes with random gaps and result
// stalls; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_window_reducer_tb;
   import pwr_pkg::*;

   localparam int unsigned STIM_COUNT    = 1250;
   localparam int unsigned CALM_TAIL     = 150;   // final requests sent without idling
   localparam int unsigned IDLE_LIMIT    = 1000;  // cycles without any handshake
   localparam int unsigned SETTLE_CYCLES = 8;     // covers the two-stage pipeline
   localparam int unsigned MAX_PHASE     = 700;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [REG_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_data;
   int unsigned          error_count;
   int unsigned          owed_count;

   bit                   no_idling;
   int unsigned          sent;
   int unsigned          quiet_left;

   pixel_window_reducer uut (.*);

   pixel_window_reducer_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hold rsp_tready low in bursts, with long quiet stretches in between.
   initial begin : rsp_backpressure
      int unsigned pick;
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         pick = $urandom_range(0, 7);
         if (!no_idling && pick == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (pick == 1) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 120)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // End the run when no channel has moved anything for too long.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: watchdog expired after %0d idle cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // Send one pixel request, possibly after an idle burst; valid stays high
   // afterwards so back-to-back requests need no extra edge.
   task automatic send_pixel(input logic [7:0] hi, input logic [7:0] lo,
                             input logic [9:0] direct);
      @(negedge clock);
      if (quiet_left > 0) begin
         quiet_left--;
      end else if (!no_idling && $urandom_range(0, 39) == 0) begin
         quiet_left = $urandom_range(30, 100);
      end else if (!no_idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, direct, lo, hi};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Drop valid, wait for every owed result, then let the pipeline drain
   // any request that produces nothing.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [1:0] mode, input logic [1:0] fmt,
                            input logic [7:0] inner, input logic [7:0] outer,
                            input logic amp);
      settle();
      put_reg(REG_MODE, CSR_W'(mode));
      put_reg(REG_FORMAT, CSR_W'(fmt));
      put_reg(REG_INNER, inner);
      put_reg(REG_OUTER, outer);
      put_reg(REG_AMP, CSR_W'(amp));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly random words, with all-zero and all-one words mixed in so the
   // search sees ties and windows without a winner.
   task automatic random_pixel(output logic [7:0] hi, output logic [7:0] lo,
                               output logic [9:0] direct);
      case ($urandom_range(0, 7))
         0: begin
            hi = '0; lo = '0; direct = '0;
         end
         1: begin
            hi = '1; lo = '1; direct = '1;
         end
         default: begin
            hi     = 8'($urandom_range(0, 255));
            lo     = 8'($urandom_range(0, 255));
            direct = 10'($urandom_range(0, 1023));
         end
      endcase
   endtask

   // Zero, the widest span, a mid value or a small span.
   function automatic logic [7:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'($urandom_range(7, 254));
         default: return 8'($urandom_range(1, 6));
      endcase
   endfunction

   initial begin : stimulus
      logic [1:0]  mode;
      logic [1:0]  fmt;
      logic [7:0]  inner;
      logic [7:0]  outer;
      logic        amp;
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [9:0]  direct;
      int unsigned span_i;
      int unsigned span_o;
      int unsigned count;
      int unsigned pick;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      no_idling  = 1'b0;
      sent       = 0;
      quiet_left = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Direct samples at both ends and alternating bits.
      configure(MODE_PASS, FMT_DIRECT, 8'd8, 8'd8, 1'b0);
      send_pixel(8'h00, 8'h00, 10'd0);
      send_pixel(8'hFF, 8'hFF, 10'd1023);
      send_pixel(8'hA5, 8'h5A, 10'h155);

      // Ten-bit serial words: empty, full, only kept bits, only dropped bits.
      configure(MODE_PASS, FMT_SPI10, 8'd8, 8'd8, 1'b0);
      send_pixel(8'h00, 8'h00, 10'h3FF);
      send_pixel(8'hFF, 8'hFF, 10'h000);
      send_pixel(8'h1F, 8'hF8, 10'h2AA);
      send_pixel(8'hE0, 8'h07, 10'h155);

      // Twelve-bit serial words at both ends.
      configure(MODE_PASS, FMT_SPI12, 8'd8, 8'd8, 1'b0);
      send_pixel(8'hFF, 8'hFF, 10'd0);
      send_pixel(8'hE0, 8'h01, 10'd0);

      // Fixed pixel ignores the word.
      configure(MODE_PASS, FMT_FIXED, 8'd8, 8'd8, 1'b0);
      send_pixel(8'h3C, 8'hC3, 10'd77);

      // Reserved mode: pixels are counted, nothing comes out.
      configure(MODE_RSVD, FMT_DIRECT, 8'd8, 8'd8, 1'b0);
      send_pixel(8'h12, 8'h34, 10'd500);
      send_pixel(8'h56, 8'h78, 10'd600);

      // Zero counts act as one: each pixel is its own line and window.
      configure(MODE_SUM, FMT_SPI12, 8'd0, 8'd0, 1'b0);
      send_pixel(8'hFF, 8'hFF, 10'd0);
      send_pixel(8'h01, 8'h20, 10'd0);

      // Line sum of three full-scale twelve-bit pixels.
      configure(MODE_SUM, FMT_SPI12, 8'd3, 8'd1, 1'b0);
      repeat (3) send_pixel(8'hFF, 8'hFF, 10'd0);

      // Darkest search: the first of two equal minima must win.
      configure(MODE_BEST, FMT_DIRECT, 8'd2, 8'd2, 1'b0);
      send_pixel(8'h00, 8'h00, 10'd900);
      send_pixel(8'h00, 8'h00, 10'd300);
      send_pixel(8'h00, 8'h00, 10'd300);
      send_pixel(8'h00, 8'h00, 10'd700);

      // Amplified search over an all-zero window has no winner.
      configure(MODE_BEST, FMT_DIRECT, 8'd2, 8'd1, 1'b1);
      send_pixel(8'h00, 8'h00, 10'd0);
      send_pixel(8'h00, 8'h00, 10'd0);

      // Random phases; counts change without restarting the window.
      while (sent < STIM_COUNT) begin
         pick = $urandom_range(0, 9);
         mode = (pick < 3) ? MODE_PASS : (pick < 6) ? MODE_SUM :
                (pick < 9) ? MODE_BEST : MODE_RSVD;
         fmt   = 2'($urandom_range(0, 3));
         amp   = 1'($urandom_range(0, 1));
         inner = pick_count();
         outer = pick_count();
         span_i = (inner == 0) ? 1 : 32'(inner);
         span_o = (outer == 0) ? 1 : 32'(outer);
         if (span_i * span_o > 600) begin
            outer  = 8'($urandom_range(0, 2));
            span_o = (outer == 0) ? 1 : 32'(outer);
         end
         count = span_i * span_o * $urandom_range(1, 3) + $urandom_range(0, span_i);
         if (count > MAX_PHASE) count = MAX_PHASE;
         if (count > STIM_COUNT - sent) count = STIM_COUNT - sent;
         configure(mode, fmt, inner, outer, amp);
         repeat (count) begin
            if (sent >= STIM_COUNT - CALM_TAIL) no_idling = 1'b1;
            random_pixel(hi, lo, direct);
            send_pixel(hi, lo, direct);
         end
      end

      // Drain, then give stray results time to show up.
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed_count != 0) @(negedge clock);
      repeat (4 * SETTLE_CYCLES) @(negedge clock);

      if (error_count == 0 && owed_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
